FILE: rtl/rlwq_pkg.sv
// Package for the recursive lock with wait queue.
// Holds the command and status codes, field widths and parameter defaults.
// No dependencies.
package rlwq_pkg;

    localparam int TID_W   = 4;
    localparam int DEPTH_W = 8;

    localparam int THREAD_COUNT_DEF = 16;
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int MAX_NEST_DEF     = 255;

    typedef enum logic
    {
        CMD_ACQUIRE = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_GRANTED = 3'd0,
        ST_NESTED  = 3'd1,
        ST_QUEUED  = 3'd2,
        ST_PARTIAL = 3'd3,
        ST_FREED   = 3'd4,
        ST_HANDOFF = 3'd5,
        ST_BADREL  = 3'd6,
        ST_REJECT  = 3'd7
    } status_t;

endpackage

FILE: rtl/recursive_lock_with_wait_queue.sv
// Recursive lock with a first-in, first-out queue of waiting thread ids.
// Single-pass datapath between an input register and a result register.
// Depends on rlwq_pkg.
//
//  Channel  Dir  Handshake          Payload
//  s_*      in   s_tvalid/s_tready  s_tuser: command; s_tdata: thread_id
//  m_*      out  m_tvalid/m_tready  m_tuser: status, woken_valid;
//                                   m_tdata: woken_thread, nest_depth
//
// One word is accepted per cycle while the result register can drain; its result
// appears when the word moves from the input register to the result register.
// The lock state is updated when a word moves from the input register to the
// result register, so the next word always sees the updated state.
// A stall on m_tready holds both registers; s_tready then drops only when
// the input register is full.
// Reset clears the lock state, the queue pointers and the waiting flags.
module recursive_lock_with_wait_queue
    import rlwq_pkg::*;
#(
    parameter int THREAD_COUNT = THREAD_COUNT_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int MAX_NEST     = MAX_NEST_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] thread_id, [7:4] zero
    input  logic        s_tuser,   // [0] command

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] woken_thread, [11:4] nest_depth, [15:12] zero
    output logic [3:0]  m_tuser    // [2:0] status, [3] woken_valid
);

    localparam int QW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int NEST_W = $clog2(MAX_NEST + 1);
    localparam int MASK_N = (THREAD_COUNT < 16) ? THREAD_COUNT : 16;

    localparam logic [8:0]        TC_LIMIT  = 9'(THREAD_COUNT);
    localparam logic [QW-1:0]     LAST_SLOT = QW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0]     Q_FULL    = CW'(QUEUE_DEPTH);
    localparam logic [NEST_W-1:0] NEST_MAX  = NEST_W'(MAX_NEST);
    localparam logic [NEST_W-1:0] NEST_ONE  = NEST_W'(1);

    // Input register
    logic             in_valid_reg;
    cmd_t             in_cmd_reg;
    logic [TID_W-1:0] in_tid_reg;

    // Result register
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic               out_woken_valid_reg;
    logic [TID_W-1:0]   out_woken_reg;
    logic [DEPTH_W-1:0] out_depth_reg;

    // Lock state
    logic              owner_valid_reg, owner_valid_next;
    logic [TID_W-1:0]  owner_id_reg, owner_id_next;
    logic [NEST_W-1:0] nest_reg, nest_next;
    logic [QW-1:0]     head_reg, head_next;
    logic [QW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [MASK_N-1:0] mask_reg, mask_next;

    // Queue storage and the registered head entry
    logic [TID_W-1:0] wait_queue_mem [QUEUE_DEPTH];
    logic [TID_W-1:0] head_mem_reg;
    logic             byp_valid_reg;
    logic [TID_W-1:0] byp_data_reg;
    logic [TID_W-1:0] head_data;

    logic               adv;
    logic               wr_en;
    logic               holder;
    logic               tid_ok;
    logic               tid_waiting;
    status_t            status;
    logic               woken_valid;
    logic [TID_W-1:0]   woken_thread;
    logic [NEST_W+DEPTH_W-1:0] depth_wide;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    assign head_data = byp_valid_reg ? byp_data_reg : head_mem_reg;
    assign holder    = owner_valid_reg && (owner_id_reg == in_tid_reg);
    assign tid_ok    = {5'd0, in_tid_reg} < TC_LIMIT;

    always_comb
    begin
        tid_waiting = 1'b0;
        for (int i = 0; i < MASK_N; i++)
        begin
            if (mask_reg[i] && (in_tid_reg == TID_W'(i)))
            begin
                tid_waiting = 1'b1;
            end
        end
    end

    always_comb
    begin
        owner_valid_next = owner_valid_reg;
        owner_id_next    = owner_id_reg;
        nest_next        = nest_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        mask_next        = mask_reg;
        wr_en            = 1'b0;
        woken_valid      = 1'b0;
        woken_thread     = '0;
        status           = ST_REJECT;

        case (in_cmd_reg)
            CMD_ACQUIRE:
            begin
                if (!tid_ok)
                begin
                    status = ST_REJECT;
                end
                else if (!owner_valid_reg)
                begin
                    owner_valid_next = 1'b1;
                    owner_id_next    = in_tid_reg;
                    nest_next        = NEST_ONE;
                    status           = ST_GRANTED;
                end
                else if (holder)
                begin
                    if (nest_reg >= NEST_MAX)
                    begin
                        status = ST_REJECT;
                    end
                    else
                    begin
                        nest_next = nest_reg + NEST_ONE;
                        status    = ST_NESTED;
                    end
                end
                else if (tid_waiting || (count_reg >= Q_FULL))
                begin
                    status = ST_REJECT;
                end
                else
                begin
                    wr_en      = 1'b1;
                    tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + QW'(1);
                    count_next = count_reg + CW'(1);
                    for (int i = 0; i < MASK_N; i++)
                    begin
                        if (in_tid_reg == TID_W'(i))
                        begin
                            mask_next[i] = 1'b1;
                        end
                    end
                    status = ST_QUEUED;
                end
            end
            CMD_RELEASE:
            begin
                if (!holder)
                begin
                    status = ST_BADREL;
                end
                else if (nest_reg > NEST_ONE)
                begin
                    nest_next = nest_reg - NEST_ONE;
                    status    = ST_PARTIAL;
                end
                else if (count_reg != '0)
                begin
                    // Hand the lock straight to the oldest waiter.
                    head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + QW'(1);
                    count_next = count_reg - CW'(1);
                    for (int i = 0; i < MASK_N; i++)
                    begin
                        if (head_data == TID_W'(i))
                        begin
                            mask_next[i] = 1'b0;
                        end
                    end
                    owner_id_next = head_data;
                    nest_next     = NEST_ONE;
                    woken_valid   = 1'b1;
                    woken_thread  = head_data;
                    status        = ST_HANDOFF;
                end
                else
                begin
                    owner_valid_next = 1'b0;
                    owner_id_next    = '0;
                    nest_next        = '0;
                    status           = ST_FREED;
                end
            end
            default:
            begin
                status = ST_REJECT;
            end
        endcase

        if (!adv)
        begin
            owner_valid_next = owner_valid_reg;
            owner_id_next    = owner_id_reg;
            nest_next        = nest_reg;
            head_next        = head_reg;
            tail_next        = tail_reg;
            count_next       = count_reg;
            mask_next        = mask_reg;
            wr_en            = 1'b0;
        end
    end

    assign depth_wide = {{DEPTH_W{1'b0}}, (owner_valid_next ? nest_next : '0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            owner_valid_reg <= 1'b0;
            owner_id_reg    <= '0;
            nest_reg        <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            mask_reg        <= '0;
            byp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            owner_valid_reg <= owner_valid_next;
            owner_id_reg    <= owner_id_next;
            nest_reg        <= nest_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            mask_reg        <= mask_next;
            // The memory returns old data when the head slot is written now.
            byp_valid_reg   <= wr_en && (tail_reg == head_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg <= cmd_t'(s_tuser);
            in_tid_reg <= s_tdata[TID_W-1:0];
        end
        if (adv)
        begin
            out_status_reg      <= status;
            out_woken_valid_reg <= woken_valid;
            out_woken_reg       <= woken_thread;
            out_depth_reg       <= depth_wide[DEPTH_W-1:0];
        end
        byp_data_reg <= in_tid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wait_queue_mem[tail_reg] <= in_tid_reg;
        end
        head_mem_reg <= wait_queue_mem[head_next];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_woken_valid_reg, out_status_reg};
    assign m_tdata  = {4'd0, out_depth_reg, out_woken_reg};

    // Every queued thread has exactly one waiting flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(mask_reg) == int'(count_reg))
    else $error("waiting flags disagree with queue count");

    // Threads only wait while someone holds the lock.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> owner_valid_reg)
    else $error("waiters present while lock is free");

    // A free lock has no nesting count and a held lock has a nonzero one.
    assert property (@(posedge clk) disable iff (!rst_n)
        owner_valid_reg == (nest_reg != '0))
    else $error("nesting count inconsistent with ownership");

    // A hand-off always reports the woken thread, and nothing else does.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_woken_valid_reg == (out_status_reg == ST_HANDOFF)))
    else $error("woken flag inconsistent with status");

endmodule

FILE: tb/recursive_lock_with_wait_queue_test.sv
// Self-checking testbench for the recursive lock with wait queue.
// It runs a directed table and then state-aware random acquire and release words. Each result
// is checked against a behavioral lock model or a typed table row. Depends on rlwq_pkg and the RTL top.
module recursive_lock_with_wait_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rlwq_pkg::*;

    localparam int THREAD_COUNT = THREAD_COUNT_DEF;
    localparam int QUEUE_DEPTH  = QUEUE_DEPTH_DEF;
    localparam int MAX_NEST     = MAX_NEST_DEF;
    localparam int RANDOM_WORDS = 520;
    localparam int CALM_WORDS   = 120;

    typedef struct packed
    {
        status_t    status;
        logic       woken_valid;
        logic [3:0] woken_thread;
        logic [7:0] nest_depth;
    } lock_result_t;

    typedef struct packed
    {
        cmd_t         cmd;
        logic [3:0]   tid;
        logic         typed;
        lock_result_t result;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = CMD_ACQUIRE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;

    // Model of the lock as the words arrive.
    logic        held_valid = 1'b0;
    logic [3:0]  held_by = 4'd0;
    int          held_depth = 0;
    logic [3:0]  waiter_ring [QUEUE_DEPTH];
    int          ring_head = 0;
    int          ring_tail = 0;
    int          ring_count = 0;
    logic [THREAD_COUNT-1:0] waiting_flags = '0;

    lock_result_t expected_results [$];
    int          fail_count = 0;
    int          words_sent = 0;
    bit          calm = 1'b0;
    bit          quiet_sender = 1'b0;

    // Walk from reset through bad releases, nesting, queuing, rejects, hand-off to three waiters and freeing.
    stim_row_t directed_rows [18] = '{
        '{CMD_RELEASE, 4'd0,  1'b1, '{ST_BADREL,  1'b0, 4'd0, 8'd0}},
        '{CMD_ACQUIRE, 4'd0,  1'b1, '{ST_GRANTED, 1'b0, 4'd0, 8'd1}},
        '{CMD_ACQUIRE, 4'd0,  1'b1, '{ST_NESTED,  1'b0, 4'd0, 8'd2}},
        '{CMD_ACQUIRE, 4'd15, 1'b1, '{ST_QUEUED,  1'b0, 4'd0, 8'd2}},
        '{CMD_ACQUIRE, 4'd15, 1'b1, '{ST_REJECT,  1'b0, 4'd0, 8'd2}},
        '{CMD_ACQUIRE, 4'd5,  1'b0, '{ST_GRANTED, 1'b0, 4'd0, 8'd0}},
        '{CMD_RELEASE, 4'd15, 1'b1, '{ST_BADREL,  1'b0, 4'd0, 8'd2}},
        '{CMD_RELEASE, 4'd0,  1'b0, '{ST_GRANTED, 1'b0, 4'd0, 8'd0}},
        '{CMD_RELEASE, 4'd0,  1'b0, '{ST_GRANTED, 1'b0, 4'd0, 8'd0}},
        '{CMD_ACQUIRE, 4'd15, 1'b0, '{ST_GRANTED, 1'b0, 4'd0, 8'd0}},
        '{CMD_ACQUIRE, 4'd10, 1'b0, '{ST_GRANTED, 1'b0, 4'd0, 8'd0}},
        '{CMD_RELEASE, 4'd15, 1'b0, '{ST_GRANTED, 1'b0, 4'd0, 8'd0}},
        '{CMD_RELEASE, 4'd15, 1'b0, '{ST_GRANTED, 1'b0, 4'd0, 8'd0}},
        '{CMD_RELEASE, 4'd5,  1'b0, '{ST_GRANTED, 1'b0, 4'd0, 8'd0}},
        '{CMD_RELEASE, 4'd10, 1'b0, '{ST_GRANTED, 1'b0, 4'd0, 8'd0}},
        '{CMD_RELEASE, 4'd10, 1'b1, '{ST_BADREL,  1'b0, 4'd0, 8'd0}},
        '{CMD_ACQUIRE, 4'd10, 1'b1, '{ST_GRANTED, 1'b0, 4'd0, 8'd1}},
        '{CMD_RELEASE, 4'd10, 1'b1, '{ST_FREED,   1'b0, 4'd0, 8'd0}}
    };

    recursive_lock_with_wait_queue uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic lock_result_t advance_lock(input cmd_t cmd, input logic [3:0] tid);
        lock_result_t res;
        logic         is_holder;
        logic [3:0]   next_owner;
        res = '{status: ST_BADREL, woken_valid: 1'b0, woken_thread: 4'd0, nest_depth: 8'd0};
        is_holder = held_valid && held_by == tid;
        if (cmd == CMD_ACQUIRE)
        begin
            if (int'(tid) >= THREAD_COUNT)
                res.status = ST_REJECT;
            else if (!held_valid)
            begin
                held_valid = 1'b1;
                held_by = tid;
                held_depth = 1;
                res.status = ST_GRANTED;
            end
            else if (is_holder)
            begin
                if (held_depth >= MAX_NEST)
                    res.status = ST_REJECT;
                else
                begin
                    held_depth++;
                    res.status = ST_NESTED;
                end
            end
            else if (waiting_flags[tid] || ring_count >= QUEUE_DEPTH)
                res.status = ST_REJECT;
            else
            begin
                waiter_ring[ring_tail] = tid;
                ring_tail = (ring_tail + 1) % QUEUE_DEPTH;
                ring_count++;
                waiting_flags[tid] = 1'b1;
                res.status = ST_QUEUED;
            end
        end
        else
        begin
            if (!is_holder)
                res.status = ST_BADREL;
            else if (held_depth > 1)
            begin
                held_depth--;
                res.status = ST_PARTIAL;
            end
            else if (ring_count > 0)
            begin
                // The oldest waiter takes the lock directly with a count of one.
                next_owner = waiter_ring[ring_head];
                ring_head = (ring_head + 1) % QUEUE_DEPTH;
                ring_count--;
                waiting_flags[next_owner] = 1'b0;
                held_by = next_owner;
                held_depth = 1;
                res.woken_valid = 1'b1;
                res.woken_thread = next_owner;
                res.status = ST_HANDOFF;
            end
            else
            begin
                held_valid = 1'b0;
                held_by = 4'd0;
                held_depth = 0;
                res.status = ST_FREED;
            end
        end
        res.nest_depth = held_valid ? 8'(held_depth) : 8'd0;
        return res;
    endfunction

    task automatic send_word(input cmd_t cmd, input logic [3:0] tid);
        int gap;
        gap = 0;
        if (!calm && !quiet_sender && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, tid};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
    endtask

    task automatic issue(input cmd_t cmd, input logic [3:0] tid);
        send_word(cmd, tid);
        expected_results.push_back(advance_lock(cmd, tid));
    endtask

    // Sender: directed table, then random words shaped by the current lock state.
    initial
    begin
        lock_result_t predicted;
        logic [3:0]   tid;
        int           pick;
        int           crowd_pct;
        crowd_pct = 30;
        wait (rst_n);
        @(posedge clk);
        foreach (directed_rows[i])
        begin
            send_word(directed_rows[i].cmd, directed_rows[i].tid);
            predicted = advance_lock(directed_rows[i].cmd, directed_rows[i].tid);
            expected_results.push_back(directed_rows[i].typed ? directed_rows[i].result
                                                              : predicted);
        end
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            calm = (n >= RANDOM_WORDS - CALM_WORDS);
            if (n % 80 == 0)
            begin
                pick = $urandom_range(0, 2);
                crowd_pct = (pick == 0) ? 10 : (pick == 1) ? 30 : 50;
                quiet_sender = ($urandom_range(0, 3) == 0);
            end
            if (n == 200)
            begin
                // Drive one holder to the nesting limit, push past it, then unwind.
                tid = 4'($urandom_range(0, 15));
                if (!held_valid)
                    issue(CMD_ACQUIRE, tid);
                while (held_depth < MAX_NEST)
                    issue(CMD_ACQUIRE, held_by);
                repeat (2) issue(CMD_ACQUIRE, held_by);
                while (held_depth > 1)
                    issue(CMD_RELEASE, held_by);
            end
            tid = 4'($urandom_range(0, 15));
            pick = $urandom_range(0, 99);
            if (held_valid)
            begin
                if (pick < crowd_pct)
                    issue(CMD_ACQUIRE, tid);
                else if (pick < crowd_pct + 20)
                    issue(CMD_ACQUIRE, held_by);
                else if (pick < 93)
                    issue(CMD_RELEASE, held_by);
                else
                    issue(CMD_RELEASE, tid);
            end
            else if (pick < 85)
                issue(CMD_ACQUIRE, tid);
            else
                issue(CMD_RELEASE, tid);
        end
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Receiver: checks each accepted word and stalls in random bursts.
    initial
    begin
        int           stall_left;
        int           holdoff_left;
        bit           holdoff_done;
        lock_result_t want;
        stall_left = 0;
        holdoff_left = 0;
        holdoff_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, tuser=%h tdata=%h",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser[2:0] !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tuser[2:0]);
                        fail_count++;
                    end
                    if (m_tuser[3] !== want.woken_valid)
                    begin
                        $display("%0t: woken_valid expected %0d actual %0d",
                                 $time, want.woken_valid, m_tuser[3]);
                        fail_count++;
                    end
                    if (m_tdata[3:0] !== want.woken_thread)
                    begin
                        $display("%0t: woken_thread expected %0d actual %0d",
                                 $time, want.woken_thread, m_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_tdata[11:4] !== want.nest_depth)
                    begin
                        $display("%0t: nest_depth expected %0d actual %0d",
                                 $time, want.nest_depth, m_tdata[11:4]);
                        fail_count++;
                    end
                end
            end
            // One long hold-off lets the block fill up and back-pressure the sender.
            if (!holdoff_done && words_sent >= 250)
            begin
                holdoff_done = 1'b1;
                holdoff_left = 150;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

endmodule
